### rtl/tce_pkg.sv
`timescale 1ns / 1ps

package tce_pkg;

    // Field widths of the stream items
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IN_ADDR_W  = 11;
    localparam int CELL_W     = 16;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;
    localparam int COLOUR_W   = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'h07;
    localparam logic [CELL_W-1:0]   BLANK_CELL   = 16'h0720;

    // Fill sweep sources
    localparam logic [1:0] FILL_BLANK = 2'd0;
    localparam logic [1:0] FILL_CLEAR = 2'd1;
    localparam logic [1:0] FILL_ZERO  = 2'd2;

    typedef struct packed {
        logic [IN_TDATA_W-CHAR_W-IN_ADDR_W-1:0] pad;
        logic [IN_ADDR_W-1:0]                   cell_address;
        logic [CHAR_W-1:0]                      char_code;
    } t_in_data;

    typedef struct packed {
        logic [OUT_TDATA_W-CELL_W-OUT_ROW_W-OUT_COL_W-2:0] pad;
        logic                                              scrolled;
        logic [OUT_COL_W-1:0]                              cursor_column;
        logic [OUT_ROW_W-1:0]                              cursor_row;
        logic [CELL_W-1:0]                                 cell_value;
    } t_out_data;

    typedef struct packed {
        logic       take;
        logic       exec_put;
        logic       copy_start;
        logic       copy_rd;
        logic       copy_wr;
        logic       fill_start;
        logic [1:0] fill_sel;
        logic       fill_wr;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             put_scroll;
        logic             copy_last;
        logic             fill_last;
    } t_dp_status;

endpackage

### rtl/tce_ctrl.sv
`timescale 1ns / 1ps

module tce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output tce_pkg::t_dp_cmd    o_cmd,
    input  tce_pkg::t_dp_status i_status
);

    localparam logic [2:0] S_INIT_START = 3'd0;
    localparam logic [2:0] S_INIT_FILL  = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_EXEC       = 3'd3;
    localparam logic [2:0] S_SCR_RD     = 3'd4;
    localparam logic [2:0] S_SCR_WR     = 3'd5;
    localparam logic [2:0] S_FILL       = 3'd6;
    localparam logic [2:0] S_RESULT     = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_INIT_START: begin
                o_cmd.fill_start = 1'b1;
                o_cmd.fill_sel   = tce_pkg::FILL_BLANK;
                n_state          = S_INIT_FILL;
            end
            S_INIT_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.command)
                    tce_pkg::CMD_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_status.put_scroll) begin
                            o_cmd.copy_start = 1'b1;
                            n_state          = S_SCR_RD;
                        end else begin
                            n_state = S_RESULT;
                        end
                    end
                    tce_pkg::CMD_CLEAR: begin
                        o_cmd.fill_start = 1'b1;
                        o_cmd.fill_sel   = tce_pkg::FILL_CLEAR;
                        n_state          = S_FILL;
                    end
                    default: begin
                        // read data is already on its way; unused code does nothing
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_SCR_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.copy_wr = 1'b1;
                if (i_status.copy_last) begin
                    o_cmd.fill_start = 1'b1;
                    o_cmd.fill_sel   = tce_pkg::FILL_ZERO;
                    n_state          = S_FILL;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/tce_datapath.sv
`timescale 1ns / 1ps

module tce_datapath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tce_pkg::t_dp_cmd                    i_cmd,
    output tce_pkg::t_dp_status                 o_status,
    input  logic [tce_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic [tce_pkg::CMD_W-1:0]           i_in_command,
    input  logic                                i_cfg_we,
    input  logic [tce_pkg::COLOUR_W-1:0]        i_cfg_data,
    output logic [tce_pkg::OUT_TDATA_W-1:0]     o_out_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int TW    = $clog2(COLUMNS + TAB_STOP);
    localparam int IAW   = tce_pkg::IN_ADDR_W;
    localparam int XW    = (AW > IAW) ? AW : IAW;
    localparam int ORW   = tce_pkg::OUT_ROW_W;
    localparam int OCW   = tce_pkg::OUT_COL_W;

    tce_pkg::t_in_data  w_in;
    tce_pkg::t_out_data w_out;

    logic [tce_pkg::CMD_W-1:0]    r_command;
    logic [tce_pkg::CHAR_W-1:0]   r_char;
    logic [IAW-1:0]               r_addr;
    logic [RW-1:0]                r_row;
    logic [CW-1:0]                r_col;
    logic [tce_pkg::COLOUR_W-1:0] r_colour;
    logic [AW-1:0]                r_cnt;
    logic [tce_pkg::CELL_W-1:0]   r_fill_val;
    logic [tce_pkg::CELL_W-1:0]   r_rd_data;
    logic                         r_scrolled;
    logic [tce_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [tce_pkg::CELL_W-1:0]   r_mem [CELLS];

    logic [TW-1:0]                w_tab_next [COLUMNS];
    logic [AW-1:0]                w_cur;
    logic [AW-1:0]                w_waddr;
    logic [tce_pkg::CELL_W-1:0]   w_wdata;
    logic                         w_wen;
    logic                         w_nl;
    logic                         w_last_row;
    logic [CW-1:0]                w_ncol;
    logic [RW-1:0]                w_nrow;
    logic [XW-1:0]                w_addr_x;
    logic                         w_addr_ok;
    logic [AW-1:0]                w_rd_addr;

    assign w_in = tce_pkg::t_in_data'(i_in_data);

    // next tab stop for every column, worked out at elaboration
    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        assign w_tab_next[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
    end

    always_comb begin
        w_cur   = AW'(int'(r_row) * COLUMNS + int'(r_col));
        w_nl    = 1'b0;
        w_wen   = 1'b0;
        w_waddr = w_cur;
        w_wdata = {r_colour, r_char};
        w_ncol  = r_col;
        unique case (r_char)
            tce_pkg::CH_BS: begin
                if (r_col != '0) begin
                    w_wen   = 1'b1;
                    w_waddr = w_cur - AW'(1);
                    w_wdata = {r_colour, 8'h00};
                    w_ncol  = r_col - CW'(1);
                end
            end
            tce_pkg::CH_CR: begin
                w_ncol = '0;
            end
            tce_pkg::CH_LF: begin
                w_nl = 1'b1;
            end
            tce_pkg::CH_TAB: begin
                if (w_tab_next[r_col] >= TW'(COLUMNS)) begin
                    w_nl = 1'b1;
                end else begin
                    w_ncol = CW'(w_tab_next[r_col]);
                end
            end
            default: begin
                w_wen = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    w_nl = 1'b1;
                end else begin
                    w_ncol = r_col + CW'(1);
                end
            end
        endcase
        w_last_row = (r_row == RW'(ROWS - 1));
        w_nrow     = r_row;
        if (w_nl) begin
            w_ncol = '0;
            if (!w_last_row) begin
                w_nrow = r_row + RW'(1);
            end
        end
    end

    assign w_addr_x  = XW'(r_addr);
    assign w_addr_ok = (32'(r_addr) < CELLS);
    assign w_rd_addr = i_cmd.copy_rd ? (r_cnt + AW'(COLUMNS))
                                     : (w_addr_ok ? w_addr_x[AW-1:0] : '0);

    // screen memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_put && w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end else if (i_cmd.copy_wr) begin
            r_mem[r_cnt] <= r_rd_data;
        end else if (i_cmd.fill_wr) begin
            r_mem[r_cnt] <= r_fill_val;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_colour <= tce_pkg::COLOUR_RESET;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_colour <= i_cfg_data;
            end
            if (i_cmd.exec_put) begin
                r_row <= w_nrow;
                r_col <= w_ncol;
            end
            if (i_cmd.fill_start) begin
                r_cnt <= (i_cmd.fill_sel == tce_pkg::FILL_ZERO) ? AW'(CELLS - COLUMNS) : '0;
            end else if (i_cmd.copy_start) begin
                r_cnt <= '0;
            end else if (i_cmd.copy_wr || i_cmd.fill_wr) begin
                r_cnt <= r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_command  <= i_in_command;
            r_char     <= w_in.char_code;
            r_addr     <= w_in.cell_address;
            r_scrolled <= 1'b0;
        end else if (i_cmd.exec_put) begin
            r_scrolled <= w_nl && w_last_row;
        end
        if (i_cmd.fill_start) begin
            unique case (i_cmd.fill_sel)
                tce_pkg::FILL_BLANK: r_fill_val <= tce_pkg::BLANK_CELL;
                tce_pkg::FILL_CLEAR: r_fill_val <= {r_colour, tce_pkg::CH_SPACE};
                default:             r_fill_val <= '0;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_data <= w_out;
        end
    end

    always_comb begin
        w_out               = '0;
        w_out.cell_value    = (r_command == tce_pkg::CMD_READ && w_addr_ok) ? r_rd_data : '0;
        w_out.cursor_row    = ORW'(r_row);
        w_out.cursor_column = OCW'(r_col);
        w_out.scrolled      = r_scrolled;
    end

    assign o_status.command    = r_command;
    assign o_status.put_scroll = w_nl && w_last_row;
    assign o_status.copy_last  = (r_cnt == AW'(CELLS - COLUMNS - 1));
    assign o_status.fill_last  = (r_cnt == AW'(CELLS - 1));
    assign o_out_data          = r_out_data;

endmodule

### rtl/text_console_engine_unit.sv
`timescale 1ns / 1ps
// Each put, read or unused command passes through the execute and result states, and the next
//   request is taken only after the result of the last one is loaded into the output register.
// A scrolling put also copies every cell below the top row up by one row, with a read state and
//   a write state per cell, then zeroes the bottom row; a clear fills every cell with spaces.
// Reset: synchronous, active low; afterwards a fill pass sets every cell of the screen to
//   light grey spaces, and no request is taken until it ends.
module text_console_engine_unit #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] char_code, [18:8] cell_address, [23:19] zero
    input  logic [tce_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] command
    input  logic [tce_pkg::CMD_W-1:0]        i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_column, [28] scrolled,
    // [31:29] zero
    output logic [tce_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // colour register write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tce_pkg::COLOUR_W-1:0]     i_cfg_data
);

    tce_pkg::t_dp_cmd    w_cmd;
    tce_pkg::t_dp_status w_status;

    // The colour register always takes a write; the user must change it only while idle.
    assign o_cfg_ready = 1'b1;

    // Sequence each request: take, execute, optional scroll copy or fill sweep, result.
    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Screen memory, cursor, colour and the output register.
    tce_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_data    (i_s_axis_tdata),
        .i_in_command (i_s_axis_tuser),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_data   (o_m_axis_tdata)
    );

endmodule

### dv/text_console_engine_checker.sv
`timescale 1ns / 1ps

module text_console_engine_checker #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [tce_pkg::IN_TDATA_W-1:0]  i_req_data,
    input  logic [tce_pkg::CMD_W-1:0]       i_req_cmd,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [tce_pkg::OUT_TDATA_W-1:0] i_rsp_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tce_pkg::COLOUR_W-1:0]    i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int MAX_REPORTS = 10;
    localparam int ROW_W       = tce_pkg::OUT_ROW_W;
    localparam int COL_W       = tce_pkg::OUT_COL_W;

    logic [tce_pkg::CELL_W-1:0]   shadow_screen [CELLS];
    logic [ROW_W-1:0]             cur_row;
    logic [COL_W-1:0]             cur_col;
    logic [tce_pkg::COLOUR_W-1:0] colour;
    tce_pkg::t_out_data           expected_replies_q [$];
    int                           mismatch_count;

    // Move to column 0 of the next row; at the bottom, shift the screen up.
    function automatic logic advance_line();
        cur_col = '0;
        if (cur_row + 1 >= ROWS) begin
            cur_row = ROW_W'(ROWS - 1);
            for (int i = 0; i + COLUMNS < CELLS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                shadow_screen[i] = '0;
            end
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic put_character(logic [tce_pkg::CHAR_W-1:0] ch);
        int col;
        int stop;
        col = int'(cur_col);
        case (ch)
            tce_pkg::CH_BS: begin
                if (col > 0) begin
                    cur_col = COL_W'(col - 1);
                    shadow_screen[cur_row * COLUMNS + col - 1] =
                        {colour, {tce_pkg::CHAR_W{1'b0}}};
                end
                return 1'b0;
            end
            tce_pkg::CH_CR: begin
                cur_col = '0;
                return 1'b0;
            end
            tce_pkg::CH_LF: return advance_line();
            tce_pkg::CH_TAB: begin
                stop = (col / TAB_STOP + 1) * TAB_STOP;
                if (stop >= COLUMNS) return advance_line();
                cur_col = COL_W'(stop);
                return 1'b0;
            end
            default: begin
                shadow_screen[cur_row * COLUMNS + col] = {colour, ch};
                if (col + 1 >= COLUMNS) return advance_line();
                cur_col = COL_W'(col + 1);
                return 1'b0;
            end
        endcase
    endfunction

    function automatic tce_pkg::t_out_data predict_reply(logic [tce_pkg::CMD_W-1:0] cmd,
                                                         tce_pkg::t_in_data req);
        tce_pkg::t_out_data reply;
        reply = '0;
        case (cmd)
            tce_pkg::CMD_PUT: reply.scrolled = put_character(req.char_code);
            tce_pkg::CMD_READ: begin
                if (req.cell_address < CELLS) begin
                    reply.cell_value = shadow_screen[req.cell_address];
                end
            end
            tce_pkg::CMD_CLEAR: begin
                foreach (shadow_screen[i]) shadow_screen[i] = {colour, tce_pkg::CH_SPACE};
            end
            default: ;
        endcase
        reply.cursor_row    = cur_row;
        reply.cursor_column = cur_col;
        return reply;
    endfunction

    always @(posedge i_clk) begin
        tce_pkg::t_out_data got;
        tce_pkg::t_out_data want;
        if (!i_rst_n) begin
            foreach (shadow_screen[i]) shadow_screen[i] = tce_pkg::BLANK_CELL;
            cur_row = '0;
            cur_col = '0;
            colour  = tce_pkg::COLOUR_RESET;
            expected_replies_q.delete();
            mismatch_count = 0;
        end else begin
            // Compare first: a reply leaving at this edge never belongs to a request
            // taken at the same edge.
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data;
                if (expected_replies_q.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("reply with no request: cell %h row %0d col %0d scrolled %0d",
                                 got.cell_value, got.cursor_row, got.cursor_column,
                                 got.scrolled);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_replies_q.pop_front();
                    if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
                        got.cursor_column !== want.cursor_column ||
                        got.scrolled !== want.scrolled) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("mismatch: expected cell %h row %0d col %0d scrolled %0d",
                                     want.cell_value, want.cursor_row, want.cursor_column,
                                     want.scrolled);
                            $display("          got      cell %h row %0d col %0d scrolled %0d",
                                     got.cell_value, got.cursor_row, got.cursor_column,
                                     got.scrolled);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) colour = i_cfg_data;
            if (i_req_valid && i_req_ready) begin
                expected_replies_q.push_back(
                    predict_reply(i_req_cmd, tce_pkg::t_in_data'(i_req_data)));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_replies_q.size();
    end

endmodule

### dv/text_console_engine_unit_tb.sv
`timescale 1ns / 1ps

module text_console_engine_unit_tb;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int TAB_STOP       = 4;
    localparam int CELLS          = ROWS * COLUMNS;
    localparam int GAP_MAX        = 18;
    localparam int HOLD_CYCLES    = 300;
    localparam int FLOOD_ITEMS    = 40;
    // Longest silent stretch of a correct run is a scroll plus a hold-off and stalls
    // on both sides; allow several times that.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 215;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CMD_BITS       = tce_pkg::CMD_W;
    localparam int CH_BITS        = tce_pkg::CHAR_W;
    localparam int ADDR_BITS      = tce_pkg::IN_ADDR_W;
    localparam int COLOUR_BITS    = tce_pkg::COLOUR_W;

    // The block treats the fourth command code as a no-op.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        BURST_TEXT,
        BURST_NEWLINES,
        BURST_TABS,
        BURST_BACKSPACES,
        BURST_RETURN,
        BURST_READS,
        BURST_CLEAR,
        BURST_UNUSED,
        BURST_NOISE
    } t_burst_kind;

    logic                                clk;
    logic                                rst_n     = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_ready;
    logic [tce_pkg::IN_TDATA_W-1:0]      req_data  = '0;
    logic [CMD_BITS-1:0]                 req_cmd   = tce_pkg::CMD_PUT;
    logic                                rsp_valid;
    logic                                rsp_ready = 1'b0;
    logic [tce_pkg::OUT_TDATA_W-1:0]     rsp_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [COLOUR_BITS-1:0]              cfg_data  = '0;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit tx_gapless  = 1'b0;
    bit hold_request = 1'b0;

    text_console_engine_unit #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_cmd),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    text_console_engine_checker #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_req_cmd     (req_cmd),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp_data    (rsp_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each reply, with calm
    // stretches of full throughput, and one long hold-off when asked for.
    initial begin
        int gap;
        int calm_left;
        bit calm;
        bit held;
        calm_left = 0;
        calm      = 1'b0;
        held      = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(10, 60);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    // Offer one request and hold it until taken; valid stays high afterwards so a
    // back-to-back request needs no extra edge.
    task automatic send_request(input logic [CMD_BITS-1:0] cmd,
                                input logic [CH_BITS-1:0] ch,
                                input logic [ADDR_BITS-1:0] addr);
        tce_pkg::t_in_data d;
        int                gap;
        d              = '0;
        d.char_code    = ch;
        d.cell_address = addr;
        gap = tx_gapless ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_data  <= d;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every reply has come back.
    task automatic settle_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_colour(input logic [COLOUR_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CH_BITS-1:0] pick_control();
        case ($urandom_range(0, 3))
            0:       return tce_pkg::CH_BS;
            1:       return tce_pkg::CH_TAB;
            2:       return tce_pkg::CH_LF;
            default: return tce_pkg::CH_CR;
        endcase
    endfunction

    // Bias reads toward the top and bottom rows, where text lands before and
    // after scrolling; keep a few past the end of the screen.
    function automatic logic [ADDR_BITS-1:0] pick_read_address();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return ADDR_BITS'($urandom_range(ROWS - 5, ROWS - 1) * COLUMNS +
                              $urandom_range(0, COLUMNS - 1));
        end
        if (r < 5) begin
            return ADDR_BITS'($urandom_range(0, 4) * COLUMNS + $urandom_range(0, COLUMNS - 1));
        end
        if (r < 9) return ADDR_BITS'($urandom_range(0, CELLS - 1));
        return ADDR_BITS'($urandom_range(CELLS, (1 << ADDR_BITS) - 1));
    endfunction

    // Play one run of related requests, shortened so it never overdraws the budget.
    task automatic play_burst(inout int budget);
        t_burst_kind        kind;
        int                 pick;
        int                 len;
        logic [CH_BITS-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 42)      begin kind = BURST_TEXT;       len = $urandom_range(1, 90); end
        else if (pick < 54) begin kind = BURST_NEWLINES;   len = $urandom_range(1, 6);  end
        else if (pick < 62) begin kind = BURST_TABS;       len = $urandom_range(1, 22); end
        else if (pick < 69) begin kind = BURST_BACKSPACES; len = $urandom_range(1, 12); end
        else if (pick < 72) begin kind = BURST_RETURN;     len = 1;                     end
        else if (pick < 89) begin kind = BURST_READS;      len = $urandom_range(1, 8);  end
        else if (pick < 93) begin kind = BURST_CLEAR;      len = 1;                     end
        else if (pick < 96) begin kind = BURST_UNUSED;     len = 1;                     end
        else                begin kind = BURST_NOISE;      len = $urandom_range(1, 6);  end
        tx_gapless = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len && budget > 0; k++) begin
            case (kind)
                BURST_TEXT: begin
                    ch = CH_BITS'($urandom_range(0, 255));
                    if ($urandom_range(0, 99) < 8) ch = pick_control();
                    send_request(tce_pkg::CMD_PUT, ch, ADDR_BITS'($urandom));
                end
                BURST_NEWLINES:
                    send_request(tce_pkg::CMD_PUT, tce_pkg::CH_LF, ADDR_BITS'($urandom));
                BURST_TABS:
                    send_request(tce_pkg::CMD_PUT, tce_pkg::CH_TAB, ADDR_BITS'($urandom));
                BURST_BACKSPACES:
                    send_request(tce_pkg::CMD_PUT, tce_pkg::CH_BS, ADDR_BITS'($urandom));
                BURST_RETURN:
                    send_request(tce_pkg::CMD_PUT, tce_pkg::CH_CR, ADDR_BITS'($urandom));
                BURST_READS:
                    send_request(tce_pkg::CMD_READ, CH_BITS'($urandom), pick_read_address());
                BURST_CLEAR:
                    send_request(tce_pkg::CMD_CLEAR, CH_BITS'($urandom), ADDR_BITS'($urandom));
                BURST_UNUSED:
                    send_request(CMD_UNUSED, CH_BITS'($urandom), ADDR_BITS'($urandom));
                default:
                    send_request(CMD_BITS'($urandom), CH_BITS'($urandom),
                                 ADDR_BITS'($urandom));
            endcase
            budget--;
        end
    endtask

    initial begin
        logic [COLOUR_BITS-1:0] phase_colour [PHASES];
        int                     budget;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads at the screen edges and beyond, puts in the reset colour,
        // every control character, the unused command and a clear.
        send_request(tce_pkg::CMD_READ, 8'h00, 11'd0);
        send_request(tce_pkg::CMD_READ, 8'hFF, ADDR_BITS'(CELLS - 1));
        send_request(tce_pkg::CMD_READ, 8'h00, ADDR_BITS'(CELLS));
        send_request(tce_pkg::CMD_READ, 8'hFF, 11'h7FF);
        send_request(tce_pkg::CMD_PUT, 8'h41, 11'h7FF);
        send_request(tce_pkg::CMD_PUT, 8'h00, 11'd0);        // character zero prints
        send_request(tce_pkg::CMD_PUT, 8'hFF, 11'd0);
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_BS, 11'd0);  // step back, blank the cell
        send_request(tce_pkg::CMD_READ, 8'h00, 11'd2);
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_TAB, 11'd0);
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_TAB, 11'd0);
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_CR, 11'd0);
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_BS, 11'd0);  // no-op at column 0
        send_request(tce_pkg::CMD_PUT, tce_pkg::CH_LF, 11'd0);
        send_request(CMD_UNUSED, 8'hFF, 11'h7FF);
        send_request(tce_pkg::CMD_CLEAR, 8'h00, 11'd0);      // cursor stays put
        send_request(tce_pkg::CMD_READ, 8'h00, ADDR_BITS'(COLUMNS + 5));
        send_request(tce_pkg::CMD_PUT, 8'h7F, 11'd0);
        settle_replies();

        // Colour extremes first, then a few arbitrary attributes.
        phase_colour[0] = 8'h00;
        phase_colour[1] = 8'hFF;
        phase_colour[2] = COLOUR_BITS'($urandom_range(1, 254));
        phase_colour[3] = 8'h0F;
        phase_colour[4] = 8'hF0;
        phase_colour[5] = COLOUR_BITS'($urandom_range(1, 254));

        for (int p = 0; p < PHASES; p++) begin
            write_colour(phase_colour[p]);
            budget = PHASE_ITEMS;
            if (p == 1) begin
                // Hold the result side off while requests keep coming back to back,
                // so the block fills up and drops tready.
                hold_request = 1'b1;
                tx_gapless   = 1'b1;
                repeat (FLOOD_ITEMS) begin
                    send_request(tce_pkg::CMD_PUT, CH_BITS'($urandom), ADDR_BITS'($urandom));
                end
                budget -= FLOOD_ITEMS;
            end
            while (budget > 0) play_burst(budget);
            settle_replies();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/tce_pkg.sv
rtl/tce_ctrl.sv
rtl/tce_datapath.sv
rtl/text_console_engine_unit.sv
dv/text_console_engine_checker.sv
dv/text_console_engine_unit_tb.sv
